// ----- hw/rtl/tmap_pkg.sv -----
// Shared constants, codes and types of the timed move acceleration planner.
`default_nettype none
package tmap_pkg;

  localparam int unsigned StopWindow = 40;
  localparam int unsigned MulW       = 88;
  localparam int unsigned NumW       = 59;
  localparam int unsigned DenW       = 48;
  localparam int unsigned CntW       = 6;
  localparam int unsigned DivSteps   = NumW;

  typedef enum logic [2:0] {
    CFG_MODE          = 3'd0,
    CFG_TARGET        = 3'd1,
    CFG_MOVE_TIME     = 3'd2,
    CFG_TIME_PER_TICK = 3'd3,
    CFG_MAX_ACCEL     = 3'd4,
    CFG_FIXED_ACCEL   = 3'd5,
    CFG_MIN_SPEED     = 3'd6
  } cfg_idx_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_EVAL = 7'b0000010,
    ST_MODE = 7'b0000100,
    ST_BANG = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  typedef enum logic [2:0] {
    STEP_CRAWL = 3'd0,
    STEP_DIST  = 3'd1,
    STEP_SPD   = 3'd2,
    STEP_2DA   = 3'd3,
    STEP_PROD  = 3'd4,
    STEP_VT    = 3'd5,
    STEP_TT    = 3'd6
  } step_e;

  typedef struct packed {
    logic signed [31:0] accel;
    logic               ovr_valid;
    logic signed [31:0] ovr_vel;
    logic               done;
  } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/timed_move_accel_planner.sv -----
// Timed move planner: per-tick acceleration command with trapezoid and cubic modes.
// Start items and idle ticks skip the datapath; their result passes from res_q to out_q in ST_OUT.
// An active tick runs the bit-serial shift-add multiplier (one multiplier bit per cycle)
// for each of its products, and the one-bit-per-cycle divider when the cubic quotient is formed.
// One item is in work at a time; moving the result to the output register frees the input.
// Reset: control and configuration registers take their reset values, the planner is idle, no result.
`default_nettype none
module timed_move_accel_planner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic signed [31:0] velocity_i,
  input  logic signed [31:0] position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] accel_o,
  output logic               override_valid_o,
  output logic signed [31:0] override_velocity_o,
  output logic               done_res_o
);

  // Configuration and control state.
  logic               mode_q;
  logic signed [31:0] target_q;
  logic [23:0]        move_time_q;
  logic [15:0]        tpt_q;
  logic [30:0]        max_q, fixed_q, vmin_q;
  logic [23:0]        rtime_q, rtime_d;
  logic               active_q, active_d;
  logic               out_valid_q, out_valid_d;
  tmap_pkg::state_e   state_q, state_d;
  tmap_pkg::step_e    step_q, step_d;
  logic [tmap_pkg::CntW-1:0] cnt_q, cnt_d;

  // Datapath registers.
  logic signed [32:0] s_q, s_d;
  logic signed [31:0] v_q, v_d;
  logic [23:0]        t_q, t_d;
  logic [63:0]        x_q, x_d;
  logic [62:0]        y_q, y_d;
  logic [55:0]        p_q, p_d;
  logic [tmap_pkg::DenW-1:0] den_q, den_d, dr_q, dr_d;
  logic [tmap_pkg::NumW-1:0] num_q, num_d, quo_q, quo_d;
  logic               nneg_q, nneg_d;
  logic [tmap_pkg::MulW-1:0] mcand_q, mcand_d, acc_q, acc_d;
  logic [32:0]        mplier_q, mplier_d;
  tmap_pkg::result_t  res_q, res_d, out_q, out_d;

  // Decision terms.
  logic               s_pos, s_neg, v_pos, v_neg, in_crawl, beyond, rem_ge;
  logic [32:0]        s_abs;
  logic [31:0]        v_abs;
  logic [30:0]        k_acc;
  logic signed [31:0] k_pos, k_neg, toward, away, vm_s;
  logic [80:0]        x_sh, lhs;
  logic signed [59:0] s_ext, s_term, p_mag, p_sgn, n_val;
  logic [tmap_pkg::NumW-1:0] n_abs;
  logic [tmap_pkg::DenW:0]   rem_shift;

  assign in_ready_o          = (state_q == tmap_pkg::ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign accel_o             = out_q.accel;
  assign override_valid_o    = out_q.ovr_valid;
  assign override_velocity_o = out_q.ovr_vel;
  assign done_res_o          = out_q.done;

  always_comb begin
    s_neg    = s_q[32];
    s_pos    = !s_q[32] && (s_q != '0);
    v_neg    = v_q[31];
    v_pos    = !v_q[31] && (v_q != '0);
    s_abs    = s_neg ? 33'(-s_q) : 33'(s_q);
    v_abs    = v_neg ? 32'(-v_q) : 32'(v_q);
    vm_s     = $signed({1'b0, vmin_q});
    in_crawl = (v_q <= vm_s) && (v_q >= -vm_s);
    k_acc    = mode_q ? max_q : fixed_q;
    k_pos    = $signed({1'b0, k_acc});
    k_neg    = -k_pos;
    toward   = s_pos ? k_pos : k_neg;
    away     = s_pos ? k_neg : k_pos;
    x_sh     = {x_q, 17'b0};
    lhs      = x_sh + 81'(y_q);
    beyond   = x_sh > 81'(acc_q[62:0]);
    // Cubic numerator 6*s*2^16 - 4*v*t, with v*t held as a magnitude.
    s_ext    = 60'(s_q);
    s_term   = (s_ext <<< 17) + (s_ext <<< 18);
    p_mag    = $signed(60'({p_q, 2'b00}));
    p_sgn    = v_neg ? -p_mag : p_mag;
    n_val    = s_term - p_sgn;
    n_abs    = n_val[59] ? tmap_pkg::NumW'(-n_val) : tmap_pkg::NumW'(n_val);
    rem_shift = {dr_q, num_q[tmap_pkg::NumW-1]};
    rem_ge    = rem_shift >= {1'b0, den_q};
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    rtime_d     = rtime_q;
    active_d    = active_q;
    out_valid_d = out_valid_q && !out_ready_i;
    s_d = s_q;  v_d = v_q;  t_d = t_q;  x_d = x_q;  y_d = y_q;  p_d = p_q;
    den_d = den_q;  dr_d = dr_q;  num_d = num_q;  quo_d = quo_q;  nneg_d = nneg_q;
    mcand_d = mcand_q;  acc_d = acc_q;  mplier_d = mplier_q;
    res_d = res_q;  out_d = out_q;

    unique case (state_q)
      tmap_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (operation_i) begin
            rtime_d  = move_time_q;
            active_d = 1'b1;
            res_d    = '0;
            state_d  = tmap_pkg::ST_OUT;
          end else if (!active_q) begin
            res_d   = '0;
            state_d = tmap_pkg::ST_OUT;
          end else begin
            t_d     = rtime_q;
            rtime_d = (rtime_q < 24'(tpt_q)) ? '0 : rtime_q - 24'(tpt_q);
            s_d     = 33'(target_q) - 33'(position_i);
            v_d     = velocity_i;
            state_d = tmap_pkg::ST_EVAL;
          end
        end
      end

      tmap_pkg::ST_EVAL: begin
        if (in_crawl && (s_abs < 33'(tmap_pkg::StopWindow))) begin
          active_d = 1'b0;
          res_d    = '{accel: '0, ovr_valid: 1'b1, ovr_vel: '0, done: 1'b1};
          state_d  = tmap_pkg::ST_OUT;
        end else if (in_crawl) begin
          v_d      = s_pos ? vm_s : -vm_s;
          acc_d    = '0;
          mcand_d  = tmap_pkg::MulW'(vmin_q);
          mplier_d = 33'(t_q);
          step_d   = tmap_pkg::STEP_CRAWL;
          state_d  = tmap_pkg::ST_MUL;
        end else begin
          state_d = tmap_pkg::ST_MODE;
        end
      end

      tmap_pkg::ST_MODE: begin
        if (!mode_q) begin
          priority if (s_neg && v_pos) begin
            res_d   = '{accel: k_neg, ovr_valid: 1'b0, ovr_vel: '0, done: 1'b0};
            state_d = tmap_pkg::ST_OUT;
          end else if (s_pos && v_neg) begin
            res_d   = '{accel: k_pos, ovr_valid: 1'b0, ovr_vel: '0, done: 1'b0};
            state_d = tmap_pkg::ST_OUT;
          end else if (k_acc == '0) begin
            res_d   = '0;
            state_d = tmap_pkg::ST_OUT;
          end else begin
            acc_d    = '0;
            mcand_d  = tmap_pkg::MulW'(k_acc);
            mplier_d = s_abs;
            step_d   = tmap_pkg::STEP_DIST;
            state_d  = tmap_pkg::ST_MUL;
          end
        end else if (t_q == '0) begin
          state_d = tmap_pkg::ST_BANG;
        end else begin
          acc_d    = '0;
          mcand_d  = tmap_pkg::MulW'(v_abs);
          mplier_d = 33'(t_q);
          step_d   = tmap_pkg::STEP_VT;
          state_d  = tmap_pkg::ST_MUL;
        end
      end

      tmap_pkg::ST_BANG: begin
        priority if (s_pos && !v_pos) begin
          res_d   = '{accel: k_pos, ovr_valid: 1'b0, ovr_vel: '0, done: 1'b0};
          state_d = tmap_pkg::ST_OUT;
        end else if (s_neg && !v_neg) begin
          res_d   = '{accel: k_neg, ovr_valid: 1'b0, ovr_vel: '0, done: 1'b0};
          state_d = tmap_pkg::ST_OUT;
        end else begin
          acc_d    = '0;
          mcand_d  = tmap_pkg::MulW'(k_acc);
          mplier_d = s_abs;
          step_d   = tmap_pkg::STEP_DIST;
          state_d  = tmap_pkg::ST_MUL;
        end
      end

      tmap_pkg::ST_MUL: begin
        if (mplier_q != '0) begin
          if (mplier_q[0]) begin
            acc_d = acc_q + mcand_q;
          end
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end else begin
          unique case (step_q)
            tmap_pkg::STEP_CRAWL: begin
              if (acc_q > tmap_pkg::MulW'({s_abs, 16'b0})) begin
                res_d   = '{accel: '0, ovr_valid: 1'b1, ovr_vel: v_q, done: 1'b0};
                state_d = tmap_pkg::ST_OUT;
              end else begin
                state_d = tmap_pkg::ST_MODE;
              end
            end
            tmap_pkg::STEP_DIST: begin
              x_d      = acc_q[63:0];
              acc_d    = '0;
              mcand_d  = tmap_pkg::MulW'(v_abs);
              mplier_d = 33'(v_abs);
              step_d   = tmap_pkg::STEP_SPD;
            end
            tmap_pkg::STEP_SPD: begin
              y_d = acc_q[62:0];
              if (mode_q || !beyond) begin
                res_d   = '{accel: beyond ? toward : away, ovr_valid: 1'b0,
                            ovr_vel: '0, done: 1'b0};
                state_d = tmap_pkg::ST_OUT;
              end else if (v_q == '0) begin
                res_d   = '{accel: toward, ovr_valid: 1'b0, ovr_vel: '0, done: 1'b0};
                state_d = tmap_pkg::ST_OUT;
              end else begin
                acc_d    = '0;
                mcand_d  = tmap_pkg::MulW'(k_acc);
                mplier_d = 33'({rtime_q, 1'b0});
                step_d   = tmap_pkg::STEP_2DA;
              end
            end
            tmap_pkg::STEP_2DA: begin
              acc_d    = '0;
              mcand_d  = tmap_pkg::MulW'(acc_q[55:0]);
              mplier_d = 33'(v_abs);
              step_d   = tmap_pkg::STEP_PROD;
            end
            tmap_pkg::STEP_PROD: begin
              // Enough time left to reach the target at this speed: keep accelerating.
              res_d   = '{accel: (tmap_pkg::MulW'(lhs) > acc_q) ? toward : '0,
                          ovr_valid: 1'b0, ovr_vel: '0, done: 1'b0};
              state_d = tmap_pkg::ST_OUT;
            end
            tmap_pkg::STEP_VT: begin
              p_d      = acc_q[55:0];
              acc_d    = '0;
              mcand_d  = tmap_pkg::MulW'(t_q);
              mplier_d = 33'(t_q);
              step_d   = tmap_pkg::STEP_TT;
            end
            tmap_pkg::STEP_TT: begin
              den_d   = acc_q[tmap_pkg::DenW-1:0];
              num_d   = n_abs;
              nneg_d  = n_val[59];
              dr_d    = '0;
              quo_d   = '0;
              cnt_d   = tmap_pkg::CntW'(tmap_pkg::DivSteps);
              state_d = tmap_pkg::ST_DIV;
            end
            default: begin
              state_d = tmap_pkg::ST_IDLE;
            end
          endcase
        end
      end

      tmap_pkg::ST_DIV: begin
        if (cnt_q != '0) begin
          num_d = num_q << 1;
          dr_d  = rem_ge ? tmap_pkg::DenW'(rem_shift - {1'b0, den_q})
                         : tmap_pkg::DenW'(rem_shift);
          quo_d = {quo_q[tmap_pkg::NumW-2:0], rem_ge};
          cnt_d = cnt_q - 1'b1;
        end else if (quo_q > tmap_pkg::NumW'(max_q)) begin
          state_d = tmap_pkg::ST_BANG;
        end else begin
          res_d   = '{accel: nneg_q ? -$signed(32'(quo_q)) : $signed(32'(quo_q)),
                      ovr_valid: 1'b0, ovr_vel: '0, done: 1'b0};
          state_d = tmap_pkg::ST_OUT;
        end
      end

      tmap_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = tmap_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tmap_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b1;
      target_q    <= '0;
      move_time_q <= '0;
      tpt_q       <= 16'd1;
      max_q       <= '0;
      fixed_q     <= 31'd65536;
      vmin_q      <= 31'd65536;
      rtime_q     <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= tmap_pkg::ST_IDLE;
      step_q      <= tmap_pkg::STEP_CRAWL;
      cnt_q       <= '0;
    end else begin
      rtime_q     <= rtime_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tmap_pkg::CFG_MODE:          mode_q      <= cfg_data_i[0];
          tmap_pkg::CFG_TARGET:        target_q    <= $signed(cfg_data_i);
          tmap_pkg::CFG_MOVE_TIME:     move_time_q <= cfg_data_i[23:0];
          tmap_pkg::CFG_TIME_PER_TICK: tpt_q       <= cfg_data_i[15:0];
          tmap_pkg::CFG_MAX_ACCEL:     max_q       <= cfg_data_i[30:0];
          tmap_pkg::CFG_FIXED_ACCEL:   fixed_q     <= cfg_data_i[30:0];
          tmap_pkg::CFG_MIN_SPEED:     vmin_q      <= cfg_data_i[30:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q      <= s_d;
    v_q      <= v_d;
    t_q      <= t_d;
    x_q      <= x_d;
    y_q      <= y_d;
    p_q      <= p_d;
    den_q    <= den_d;
    dr_q     <= dr_d;
    num_q    <= num_d;
    quo_q    <= quo_d;
    nneg_q   <= nneg_d;
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
    mplier_q <= mplier_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i |=> active_q)
    else $error("start beat did not arm the planner");

  a_done_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> override_valid_o && (accel_o == '0)
                                  && (override_velocity_o == '0))
    else $error("done result carries motion");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmap_pkg::ST_DIV) |-> (den_q != '0))
    else $error("divider started with zero divisor");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register lost one-hot coding");

endmodule
`default_nettype wire

// ----- sim/tmap_checker.sv -----
// Checker for the timed move planner: mirrors the registers, predicts each result and compares.
module tmap_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               operation_i,
  input  logic signed [31:0] velocity_i,
  input  logic signed [31:0] position_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] accel_i,
  input  logic               override_valid_i,
  input  logic signed [31:0] override_velocity_i,
  input  logic               done_res_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o
);

  logic               cubic_mode;
  logic signed [31:0] target;
  logic [23:0]        move_len;
  logic [15:0]        tick_len;
  logic [30:0]        accel_limit;
  logic [30:0]        trap_accel;
  logic [30:0]        crawl_speed;
  logic [23:0]        time_left;
  logic               moving;
  tmap_pkg::result_t  expected_cmds[$];

  function automatic longint unsigned absval(longint x);
    return x < 0 ? longint'(-x) : longint'(x);
  endfunction

  function automatic logic [127:0] prod(longint unsigned x, longint unsigned y);
    return {64'd0, x} * {64'd0, y};
  endfunction

  // True when the distance left is longer than the braking distance v^2/(2a).
  function automatic bit beyond_brake(longint unsigned span, longint unsigned spd,
                                      longint unsigned acc);
    return prod(span << 17, acc) > prod(spd, spd);
  endfunction

  function automatic longint trap_cmd(longint s, longint v, longint unsigned d);
    longint a;
    longint unsigned span, spd;
    logic [127:0] lhs;
    a = longint'(trap_accel);
    span = absval(s);
    spd = absval(v);
    if (s < 0 && v > 0) return -a;
    if (s > 0 && v < 0) return a;
    if (a == 0) return 0;
    if (beyond_brake(span, spd, a)) begin
      lhs = prod(span << 17, a) + prod(spd, spd);
      if (spd == 0 || lhs > prod(2 * d * a, spd)) return s > 0 ? a : -a;
      return 0;
    end
    return s > 0 ? -a : a;
  endfunction

  function automatic longint bang_cmd(longint s, longint v);
    longint a;
    a = longint'(accel_limit);
    if (s > 0 && v <= 0) return a;
    if (s < 0 && v >= 0) return -a;
    if (beyond_brake(absval(s), absval(v), a)) return s > 0 ? a : -a;
    return s > 0 ? -a : a;
  endfunction

  function automatic longint cubic_cmd(longint s, longint v, longint unsigned t);
    longint a, ti, q;
    a = longint'(accel_limit);
    ti = longint'(t);
    if (t == 0) return bang_cmd(s, v);
    q = (s * 6 * 65536 - v * 4 * ti) / (ti * ti);
    if (q > a || q < -a) return bang_cmd(s, v);
    return q;
  endfunction

  // Works out the command for one beat and advances the move state.
  function automatic tmap_pkg::result_t plan_tick(logic op, logic signed [31:0] vel,
                                                  logic signed [31:0] pos);
    tmap_pkg::result_t r;
    longint v, s, vm, a;
    longint unsigned t;
    r = '0;
    if (op) begin
      time_left = move_len;
      moving = 1'b1;
      return r;
    end
    if (!moving) return r;
    t = time_left;
    time_left = (t < tick_len) ? 24'd0 : 24'(t - tick_len);
    v = longint'(vel);
    s = longint'(target) - longint'(pos);
    vm = longint'(crawl_speed);
    if (v <= vm && v >= -vm) begin
      if (absval(s) < tmap_pkg::StopWindow) begin
        moving = 1'b0;
        r.ovr_valid = 1'b1;
        r.done = 1'b1;
        return r;
      end
      v = s > 0 ? vm : -vm;
      if (t * longint'(crawl_speed) > (absval(s) << 16)) begin
        r.ovr_valid = 1'b1;
        r.ovr_vel = v[31:0];
        return r;
      end
    end
    a = cubic_mode ? cubic_cmd(s, v, t) : trap_cmd(s, v, time_left);
    r.accel = a[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tmap_pkg::result_t got, want;
    if (!rst_ni) begin
      cubic_mode = 1'b1;
      target = '0;
      move_len = '0;
      tick_len = 16'd1;
      accel_limit = '0;
      trap_accel = 31'd65536;
      crawl_speed = 31'd65536;
      time_left = '0;
      moving = 1'b0;
      expected_cmds.delete();
      errors_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (tmap_pkg::cfg_idx_e'(cfg_index_i))
          tmap_pkg::CFG_MODE:          cubic_mode = cfg_data_i[0];
          tmap_pkg::CFG_TARGET:        target = cfg_data_i;
          tmap_pkg::CFG_MOVE_TIME:     move_len = cfg_data_i[23:0];
          tmap_pkg::CFG_TIME_PER_TICK: tick_len = cfg_data_i[15:0];
          tmap_pkg::CFG_MAX_ACCEL:     accel_limit = cfg_data_i[30:0];
          tmap_pkg::CFG_FIXED_ACCEL:   trap_accel = cfg_data_i[30:0];
          tmap_pkg::CFG_MIN_SPEED:     crawl_speed = cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = '{accel_i, override_valid_i, override_velocity_i, done_res_i};
        if (expected_cmds.size() == 0) begin
          $error("result beat with nothing expected");
          errors_o++;
        end else begin
          want = expected_cmds.pop_front();
          checked_o++;
          if (got.accel !== want.accel) begin
            $error("accel: expected %0d, got %0d", want.accel, got.accel);
            errors_o++;
          end
          if (got.ovr_valid !== want.ovr_valid) begin
            $error("override_valid: expected %0d, got %0d", want.ovr_valid, got.ovr_valid);
            errors_o++;
          end
          if (got.ovr_vel !== want.ovr_vel) begin
            $error("override_velocity: expected %0d, got %0d", want.ovr_vel, got.ovr_vel);
            errors_o++;
          end
          if (got.done !== want.done) begin
            $error("done_res: expected %0d, got %0d", want.done, got.done);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_cmds.push_back(plan_tick(operation_i, velocity_i, position_i));
    end
    pending_o = expected_cmds.size();
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the planner testbench: stimulus, random stalls, watchdog and verdict.
module testbench;

  localparam int NumPhases = 40;
  localparam int WatchLimit = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               operation_i = 1'b0;
  logic signed [31:0] velocity_i = '0;
  logic signed [31:0] position_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] accel_o;
  logic               override_valid_o;
  logic signed [31:0] override_velocity_o;
  logic               done_res_o;

  int errors, pending, checked;
  int sent = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  logic signed [31:0] cur_target = '0;
  logic [30:0]        cur_min_speed = 31'd65536;

  timed_move_accel_planner DUT (.*);

  tmap_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .velocity_i, .position_i,
    .out_valid_i(out_valid_o), .out_ready_i, .accel_i(accel_o),
    .override_valid_i(override_valid_o), .override_velocity_i(override_velocity_o),
    .done_res_i(done_res_o), .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver side: ready drops in random bursts except in the calm tail.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("[timed_move_accel_planner] ERROR");
      $finish;
    end
  end

  // Called at a clock edge; returns at the edge where the beat is taken.
  task automatic send(logic op, logic signed [31:0] vel, logic signed [31:0] pos);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    velocity_i <= vel;
    position_i <= pos;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_regs(logic md, logic signed [31:0] tgt, logic [23:0] mt,
                            logic [15:0] tpt, logic [30:0] ma, logic [30:0] fa,
                            logic [30:0] ms);
    logic [31:0] vals[7];
    vals = '{32'(md), tgt, 32'(mt), 32'(tpt), 32'(ma), 32'(fa), 32'(ms)};
    for (int i = 0; i < 7; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= 3'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_target = tgt;
    cur_min_speed = ms;
    @(posedge clk_i);
  endtask

  function automatic logic [30:0] pick_accel(bit allow_zero);
    case ($urandom_range(0, 5))
      0: return allow_zero ? 31'd0 : 31'd1;
      1: return 31'h7FFFFFFF;
      2: return 31'($urandom_range(1, 1 << 12));
      default: return 31'($urandom_range(1, 1 << 22));
    endcase
  endfunction

  task automatic random_regs();
    logic signed [31:0] tgt;
    logic [23:0] mt;
    logic [15:0] tpt;
    logic [30:0] ms;
    tgt = ($urandom_range(0, 7) == 0) ? $urandom : $signed($urandom_range(0, 20000)) - 10000;
    case ($urandom_range(0, 4))
      0: mt = '0;
      1: mt = 24'hFFFFFF;
      default: mt = 24'($urandom_range(1, 3000));
    endcase
    case ($urandom_range(0, 4))
      0: tpt = '0;
      1: tpt = 16'hFFFF;
      default: tpt = 16'($urandom_range(1, 50));
    endcase
    ms = ($urandom_range(0, 5) == 0) ? 31'($urandom) : 31'($urandom_range(1, 1 << 18));
    write_regs(1'($urandom), tgt, mt, tpt, pick_accel(1'b1), pick_accel(1'b0), ms);
  endtask

  task automatic random_tick();
    logic signed [31:0] off, vel;
    int unsigned m;
    m = cur_min_speed;
    case ($urandom_range(0, 5))
      0: off = $signed($urandom_range(0, 78)) - 39;
      1: off = $signed($urandom_range(0, 1000)) - 500;
      2: off = $signed($urandom_range(0, 200000)) - 100000;
      3: off = $urandom;
      default: off = $signed($urandom_range(0, 10000)) - 5000;
    endcase
    case ($urandom_range(0, 5))
      0: vel = $signed($urandom_range(0, m));
      1: vel = '0;
      2: vel = $urandom;
      3: vel = $signed($urandom_range(0, 1 << 20));
      default: vel = $signed(m + $urandom_range(0, 1));
    endcase
    if ($urandom_range(0, 1) == 1) vel = -vel;
    send(1'b0, vel, cur_target - off);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings (cubic mode, zero accel limit, zero move time).
    send(1'b0, 32'sd0, 32'sd0);
    send(1'b1, 32'sd0, 32'sd0);
    send(1'b0, 32'sd0, 32'sd5);
    send(1'b0, 32'sd0, 32'sd0);
    send(1'b1, 32'sd0, 32'sd0);
    send(1'b0, 32'sh7FFFFFFF, 32'sh80000000);
    send(1'b0, 32'sh80000000, 32'sh7FFFFFFF);
    send(1'b0, 32'sd65536, 32'sd1000);
    send(1'b0, -32'sd65537, -32'sd1000);
    drain();
    // Directed: trapezoid with every register at its top value.
    write_regs(1'b0, 32'sh7FFFFFFF, 24'hFFFFFF, 16'hFFFF, 31'h7FFFFFFF,
               31'h7FFFFFFF, 31'h7FFFFFFF);
    send(1'b1, 32'sd0, 32'sd0);
    send(1'b0, 32'sd0, 32'sh80000000);
    send(1'b0, 32'sh80000000, 32'sh80000000);
    send(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    drain();
    // Directed: bottom values, slow crawl and tiny accelerations.
    write_regs(1'b0, 32'sh80000000, 24'd0, 16'd0, 31'd0, 31'd1, 31'd1);
    send(1'b1, 32'sd0, 32'sd0);
    send(1'b0, 32'sd0, 32'sh7FFFFFFF);
    send(1'b0, 32'sd5, 32'sh80000000 + 32'sd1000);
    send(1'b0, -32'sd5, 32'sh80000000 - 32'sd1000);
    send(1'b0, 32'sd1, 32'sh80000000 + 32'sd39);
    drain();
    write_regs(1'b1, 32'sd1000, 24'd500, 16'd1, 31'd1 << 20, 31'd65536, 31'd65536);
    send(1'b1, 32'sd0, 32'sd0);
    send(1'b0, 32'sd0, 32'sd0);
    send(1'b0, 32'sd131072, 32'sd990);
    send(1'b0, 32'sd65536, 32'sd961);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph >= NumPhases - 5) calm = 1'b1;
      random_regs();
      send(1'b1, $urandom, $urandom);
      for (int k = 0; k < 34; k++) begin
        if ($urandom_range(0, 29) == 0) send(1'b1, $urandom, $urandom);
        else random_tick();
      end
      drain();
    end

    repeat (250) @(posedge clk_i);
    $display("Sent %0d beats over %0d register settings; %0d results compared.",
             sent, NumPhases + 4, checked);
    if (errors == 0 && pending == 0) begin
      $display("[timed_move_accel_planner] OK");
    end else begin
      $display("[timed_move_accel_planner] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tmap_pkg.sv
hw/rtl/timed_move_accel_planner.sv
sim/tmap_checker.sv
sim/testbench.sv
